// ===== src/h264rtp_pkg.sv =====
`default_nettype none

package h264rtp_pkg;

  // Fill counters cover the widest limit the configuration register can hold.
  localparam int unsigned FILL_W = 19;
  localparam int unsigned OFFSET_W = 18;

  // Depth of the queue between the parser and the frame store side.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Configuration register indexes.
  localparam logic CFG_AVC_MODE = 1'b0;
  localparam logic CFG_MAX_FRAME_LIMIT = 1'b1;

  // One parsed byte, as the front end hands it to the back end.
  typedef struct packed {
    logic       clear;       // empty the frame before this byte
    logic       abandon;     // drop any open unit (new packet header)
    logic       put;         // a unit byte is offered to the frame store
    logic [7:0] put_byte;
    logic       unit_start;  // the offered byte opens a unit
    logic       finish;      // the open unit ends on this byte
    logic       short_pkt;
    logic       frag_first;
    logic       frag_last;
    logic [4:0] nal_type;
  } h264rtp_cmd_t;

  // One result item.
  typedef struct packed {
    logic                out_valid;
    logic [7:0]          out_byte;
    logic [OFFSET_W-1:0] out_offset;
    logic                unit_start;
    logic                unit_end;
    logic                unit_ok;
    logic                overflow;
    logic                short_packet;
    logic                frag_first;
    logic                frag_last;
    logic [4:0]          nal_type;
  } h264rtp_res_t;

endpackage

`default_nettype wire

// ===== src/h264rtp_ifs.sv =====
`default_nettype none

// Payload byte channel.
interface h264rtp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       packet_start;
  logic       packet_end;
  logic       frame_clear;

  modport source (output valid, output data_byte, output packet_start,
                  output packet_end, output frame_clear, input ready);
  modport sink (input valid, input data_byte, input packet_start,
                input packet_end, input frame_clear, output ready);
endinterface

// Result channel, one result per payload byte.
interface h264rtp_out_if;
  logic        valid;
  logic        ready;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic [17:0] out_offset;
  logic        unit_start;
  logic        unit_end;
  logic        unit_ok;
  logic        overflow;
  logic        short_packet;
  logic        frag_first;
  logic        frag_last;
  logic [4:0]  nal_type;

  modport source (output valid, output out_valid, output out_byte, output out_offset,
                  output unit_start, output unit_end, output unit_ok, output overflow,
                  output short_packet, output frag_first, output frag_last,
                  output nal_type, input ready);
  modport sink (input valid, input out_valid, input out_byte, input out_offset,
                input unit_start, input unit_end, input unit_ok, input overflow,
                input short_packet, input frag_first, input frag_last,
                input nal_type, output ready);
endinterface

`default_nettype wire

// ===== src/h264_rtp_depacketizer.sv =====
`default_nettype none

// H.264 RTP payload depacketizer. Payload bytes enter one per request on in_if,
// with packet start and end marks, and every byte yields exactly one result on
// out_if: the byte to write into the frame store (or the rebuilt NAL header of a
// first FU fragment) with its offset, unit start and end marks, commit or
// overflow status, a short packet flag and the packet's NAL type and fragment
// bits. The block takes one byte per clock while the queue is not full; a result
// passes from the parser-to-store queue into the output register and then waits
// there until it is taken. The parser keeps accepting while the output stalls
// until the two-entry queue is full. Configuration (avc_mode, max_frame_limit) is
// written through cfg_we/cfg_index/cfg_wdata; the user must write it only
// while no request is in flight, as the block does not enforce this. The
// effective frame limit is the smaller of max_frame_limit and MAX_FRAME_BYTES.
module h264_rtp_depacketizer
  import h264rtp_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 262144
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [18:0] cfg_wdata,
  h264rtp_in_if.sink       in_if,
  h264rtp_out_if.source    out_if
);

  logic              avc_mode_r;
  logic [FILL_W-1:0] max_frame_limit_r;
  logic              in_accept;
  logic              q_full;
  logic              q_not_empty;
  logic              q_pop;
  h264rtp_cmd_t      front_cmd;
  h264rtp_cmd_t      head_cmd;
  logic              res_valid;
  h264rtp_res_t      res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avc_mode_r <= 1'b0;
      max_frame_limit_r <= FILL_W'(262144);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_AVC_MODE:        avc_mode_r <= cfg_wdata[0];
        CFG_MAX_FRAME_LIMIT: max_frame_limit_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign in_if.ready = !q_full;
  assign in_accept = in_if.valid && !q_full;

  h264rtp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .avc_mode     (avc_mode_r),
    .in_valid     (in_if.valid),
    .data_byte    (in_if.data_byte),
    .packet_start (in_if.packet_start),
    .packet_end   (in_if.packet_end),
    .frame_clear  (in_if.frame_clear),
    .accept       (!q_full),
    .cmd          (front_cmd)
  );

  h264rtp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_cmd  (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_cmd  (head_cmd)
  );

  h264rtp_back #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .max_frame_limit (max_frame_limit_r),
    .cmd_valid       (q_not_empty),
    .cmd             (head_cmd),
    .cmd_pop         (q_pop),
    .res_valid       (res_valid),
    .res             (res),
    .res_ready       (out_if.ready)
  );

  // Result channel.
  assign out_if.valid = res_valid;
  assign out_if.out_valid = res.out_valid;
  assign out_if.out_byte = res.out_byte;
  assign out_if.out_offset = res.out_offset;
  assign out_if.unit_start = res.unit_start;
  assign out_if.unit_end = res.unit_end;
  assign out_if.unit_ok = res.unit_ok;
  assign out_if.overflow = res.overflow;
  assign out_if.short_packet = res.short_packet;
  assign out_if.frag_first = res.frag_first;
  assign out_if.frag_last = res.frag_last;
  assign out_if.nal_type = res.nal_type;

endmodule

`default_nettype wire

// ===== src/h264rtp_front.sv =====
`default_nettype none

module h264rtp_front
  import h264rtp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         avc_mode,
  input  wire logic         in_valid,
  input  wire logic [7:0]   data_byte,
  input  wire logic         packet_start,
  input  wire logic         packet_end,
  input  wire logic         frame_clear,
  input  wire logic         accept,
  output h264rtp_cmd_t      cmd
);

  typedef enum logic [2:0] {
    PH_HDR   = 3'd0,
    PH_SKIPH = 3'd1,
    PH_SIZEHI = 3'd2,
    PH_SIZELO = 3'd3,
    PH_SKIPU = 3'd4,
    PH_UNIT  = 3'd5,
    PH_FUH   = 3'd6,
    PH_RUN   = 3'd7
  } phase_t;

  localparam logic [4:0] TYPE_STAP_A = 5'd24;
  localparam logic [4:0] TYPE_STAP_B = 5'd25;
  localparam logic [4:0] TYPE_MTAP16 = 5'd26;
  localparam logic [4:0] TYPE_MTAP24 = 5'd27;
  localparam logic [4:0] TYPE_FU_A   = 5'd28;
  localparam logic [4:0] TYPE_FU_B   = 5'd29;

  phase_t      phase_r, phase_nxt;
  logic [4:0]  type_r, type_nxt;
  logic [2:0]  skip_r, skip_nxt;
  logic [15:0] unit_left_r, unit_left_nxt;
  logic [2:0]  keep_r, keep_nxt;
  logic        first_r, first_nxt;
  logic        last_r, last_nxt;
  logic        open_r, open_nxt;

  // Parse one byte: decide the next phase and what the back end must do.
  always_comb begin
    logic [2:0]  skip_dec;
    logic [15:0] size_v;
    logic [15:0] left_dec;

    phase_nxt = phase_r;
    type_nxt = type_r;
    skip_nxt = skip_r;
    unit_left_nxt = unit_left_r;
    keep_nxt = keep_r;
    first_nxt = first_r;
    last_nxt = last_r;
    open_nxt = open_r;
    cmd = '0;
    cmd.clear = frame_clear;
    skip_dec = (skip_r == 3'd0) ? 3'd0 : skip_r - 3'd1;
    size_v = {unit_left_r[15:8], data_byte};
    left_dec = (unit_left_r == 16'd0) ? 16'd0 : unit_left_r - 16'd1;

    if (packet_start || phase_r == PH_HDR) begin
      // Payload header byte: classify the packet.
      cmd.abandon = 1'b1;
      open_nxt = 1'b0;
      type_nxt = avc_mode ? 5'd0 : data_byte[4:0];
      first_nxt = 1'b1;
      last_nxt = 1'b1;
      if (type_nxt == TYPE_STAP_A) begin
        phase_nxt = PH_SIZEHI;
      end else if (type_nxt == TYPE_STAP_B || type_nxt == TYPE_MTAP16 ||
                   type_nxt == TYPE_MTAP24) begin
        skip_nxt = 3'd2;
        phase_nxt = PH_SKIPH;
      end else if (type_nxt == TYPE_FU_A || type_nxt == TYPE_FU_B) begin
        keep_nxt = data_byte[7:5];
        phase_nxt = PH_FUH;
      end else begin
        cmd.put = 1'b1;
        cmd.put_byte = data_byte;
        cmd.unit_start = 1'b1;
        open_nxt = 1'b1;
        phase_nxt = PH_RUN;
      end
    end else begin
      case (phase_r)
        PH_SKIPH: begin
          skip_nxt = skip_dec;
          if (skip_dec == 3'd0) begin
            phase_nxt = (type_r == TYPE_FU_B) ? PH_RUN : PH_SIZEHI;
          end
        end
        PH_SIZEHI: begin
          unit_left_nxt = {data_byte, 8'h00};
          phase_nxt = PH_SIZELO;
        end
        PH_SIZELO: begin
          unit_left_nxt = size_v;
          if (type_r == TYPE_MTAP16) begin
            skip_nxt = 3'd3;
            phase_nxt = PH_SKIPU;
          end else if (type_r == TYPE_MTAP24) begin
            skip_nxt = 3'd4;
            phase_nxt = PH_SKIPU;
          end else begin
            phase_nxt = (size_v == 16'd0) ? PH_SIZEHI : PH_UNIT;
          end
        end
        PH_SKIPU: begin
          skip_nxt = skip_dec;
          if (skip_dec == 3'd0) begin
            phase_nxt = (unit_left_r == 16'd0) ? PH_SIZEHI : PH_UNIT;
          end
        end
        PH_UNIT: begin
          cmd.put = 1'b1;
          cmd.put_byte = data_byte;
          cmd.unit_start = !open_r;
          open_nxt = 1'b1;
          unit_left_nxt = left_dec;
          if (left_dec == 16'd0) begin
            cmd.finish = 1'b1;
            open_nxt = 1'b0;
            phase_nxt = PH_SIZEHI;
          end
        end
        PH_FUH: begin
          // FU header: fragment bits and the rebuilt NAL header on the first one.
          first_nxt = data_byte[7];
          last_nxt = data_byte[6];
          if (data_byte[7]) begin
            cmd.put = 1'b1;
            cmd.put_byte = {keep_r, data_byte[4:0]};
            cmd.unit_start = !open_r;
            open_nxt = 1'b1;
          end
          if (type_r == TYPE_FU_B) begin
            skip_nxt = 3'd2;
            phase_nxt = PH_SKIPH;
          end else begin
            phase_nxt = PH_RUN;
          end
        end
        default: begin
          cmd.put = 1'b1;
          cmd.put_byte = data_byte;
          cmd.unit_start = !open_r;
          open_nxt = 1'b1;
        end
      endcase
    end

    // Packet end: flag a cut header field and close any open unit.
    if (packet_end) begin
      cmd.short_pkt = (phase_nxt == PH_SKIPH) || (phase_nxt == PH_SIZELO) ||
                      (phase_nxt == PH_SKIPU) || (phase_nxt == PH_FUH);
      if (open_nxt) begin
        cmd.finish = 1'b1;
        open_nxt = 1'b0;
      end
      phase_nxt = PH_HDR;
    end

    cmd.frag_first = first_nxt;
    cmd.frag_last = last_nxt;
    cmd.nal_type = type_nxt;
  end

  // Parser state advances on each accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR;
      type_r <= 5'd0;
      skip_r <= 3'd0;
      unit_left_r <= 16'd0;
      keep_r <= 3'd0;
      first_r <= 1'b1;
      last_r <= 1'b1;
      open_r <= 1'b0;
    end else if (accept && in_valid) begin
      phase_r <= phase_nxt;
      type_r <= type_nxt;
      skip_r <= skip_nxt;
      unit_left_r <= unit_left_nxt;
      keep_r <= keep_nxt;
      first_r <= first_nxt;
      last_r <= last_nxt;
      open_r <= open_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/h264rtp_queue.sv =====
`default_nettype none

module h264rtp_queue
  import h264rtp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire h264rtp_cmd_t push_cmd,
  output logic              full,
  input  wire logic         pop,
  output logic              not_empty,
  output h264rtp_cmd_t      head_cmd
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  h264rtp_cmd_t     entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full = (count_r == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_cmd = entry_r[rd_ptr_r];

  // Entries carry no reset; only the pointers and count do.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/h264rtp_back.sv =====
`default_nettype none

module h264rtp_back
  import h264rtp_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 262144
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [FILL_W-1:0] max_frame_limit,
  input  wire logic          cmd_valid,
  input  wire h264rtp_cmd_t  cmd,
  output logic               cmd_pop,
  output logic               res_valid,
  output h264rtp_res_t       res,
  input  wire logic          res_ready
);

  localparam logic [31:0] MAX_BYTES_W = 32'(MAX_FRAME_BYTES);

  logic [FILL_W-1:0] frame_r, frame_nxt;
  logic [FILL_W-1:0] pend_r, pend_nxt;
  logic              drop_r, drop_nxt;
  logic              res_valid_r;
  h264rtp_res_t      res_r, res_nxt;

  assign cmd_pop = cmd_valid && (!res_valid_r || res_ready);
  assign res_valid = res_valid_r;
  assign res = res_r;

  // Frame store bookkeeping for one parsed byte.
  always_comb begin
    logic [FILL_W:0] pend_inc;
    logic            over;

    frame_nxt = frame_r;
    pend_nxt = pend_r;
    drop_nxt = drop_r;
    res_nxt = '0;

    if (cmd.clear) begin
      frame_nxt = '0;
      pend_nxt = '0;
      drop_nxt = 1'b0;
    end
    if (cmd.abandon) begin
      pend_nxt = frame_nxt;
      drop_nxt = 1'b0;
    end

    pend_inc = {1'b0, pend_nxt} + 1'b1;
    over = (pend_inc > {1'b0, max_frame_limit}) ||
           ({{(32 - FILL_W - 1){1'b0}}, pend_inc} > MAX_BYTES_W);

    // A byte that would push the frame fill past the limit drops the whole unit.
    if (cmd.put) begin
      res_nxt.unit_start = cmd.unit_start;
      if (!drop_nxt) begin
        if (over) begin
          drop_nxt = 1'b1;
        end else begin
          res_nxt.out_valid = 1'b1;
          res_nxt.out_byte = cmd.put_byte;
          res_nxt.out_offset = pend_nxt[OFFSET_W-1:0];
          pend_nxt = pend_inc[FILL_W-1:0];
        end
      end
    end

    // Commit or discard the unit when it ends.
    if (cmd.finish) begin
      res_nxt.unit_end = 1'b1;
      if (drop_nxt) begin
        res_nxt.overflow = 1'b1;
      end else begin
        res_nxt.unit_ok = 1'b1;
        frame_nxt = pend_nxt;
      end
      pend_nxt = frame_nxt;
      drop_nxt = 1'b0;
    end

    res_nxt.short_packet = cmd.short_pkt;
    res_nxt.frag_first = cmd.frag_first;
    res_nxt.frag_last = cmd.frag_last;
    res_nxt.nal_type = cmd.nal_type;
  end

  // Fill counters and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r <= '0;
      pend_r <= '0;
      drop_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (cmd_pop) begin
        frame_r <= frame_nxt;
        pend_r <= pend_nxt;
        drop_r <= drop_nxt;
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/h264rtp_checker.sv =====
`default_nettype none

module h264rtp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        res_req_valid,
  input wire logic        res_req_ready,
  input wire logic        res_out_valid,
  input wire logic [7:0]  res_out_byte,
  input wire logic [17:0] res_out_offset,
  input wire logic        res_unit_end,
  input wire logic        res_unit_ok,
  input wire logic        res_overflow
);

  // No result request may be left over from before reset.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !res_req_valid)
    else $error("result request valid right after reset");

  // A stalled result request stays up.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_req_valid && !res_req_ready |=> res_req_valid)
    else $error("result request withdrawn while stalled");

  // A unit that ends is either committed or dropped, never both.
  a_end_status: assert property (@(posedge clk) disable iff (!rst_n)
    res_req_valid |-> ((res_unit_ok || res_overflow) == res_unit_end) &&
                      !(res_unit_ok && res_overflow))
    else $error("unit end status inconsistent");

  // An unwritten byte shows a zero byte and offset.
  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    res_req_valid && !res_out_valid |-> res_out_byte == 8'd0 && res_out_offset == 18'd0)
    else $error("byte or offset set on a result with no store write");

endmodule

bind h264_rtp_depacketizer h264rtp_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .res_req_valid  (out_if.valid),
  .res_req_ready  (out_if.ready),
  .res_out_valid  (out_if.out_valid),
  .res_out_byte   (out_if.out_byte),
  .res_out_offset (out_if.out_offset),
  .res_unit_end   (out_if.unit_end),
  .res_unit_ok    (out_if.unit_ok),
  .res_overflow   (out_if.overflow)
);

`default_nettype wire

// ===== dv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import h264rtp_pkg::*;

  localparam int FRAME_BYTES_MAX = 262144;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_COUNT = 6;
  localparam int PHASE_BYTES = 267;

  // Packet types that get special handling.
  localparam logic [4:0] NAL_STAP_A = 5'd24;
  localparam logic [4:0] NAL_STAP_B = 5'd25;
  localparam logic [4:0] NAL_MTAP16 = 5'd26;
  localparam logic [4:0] NAL_MTAP24 = 5'd27;
  localparam logic [4:0] NAL_FU_A = 5'd28;
  localparam logic [4:0] NAL_FU_B = 5'd29;

  typedef enum logic [2:0] {
    ST_HEADER,
    ST_SKIP_HDR,
    ST_SIZE_HI,
    ST_SIZE_LO,
    ST_SKIP_UNIT,
    ST_UNIT,
    ST_FU_HDR,
    ST_PAYLOAD
  } parse_phase_e;

  // One payload byte request with its packet marks.
  typedef struct packed {
    logic [7:0] data;
    logic       pkt_start;
    logic       pkt_end;
    logic       clear;
  } payload_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_AVC_MODE;
  logic [18:0] cfg_wdata = '0;

  logic       drv_valid = 1'b0;
  logic [7:0] drv_byte = '0;
  logic       drv_start = 1'b0;
  logic       drv_end = 1'b0;
  logic       drv_clear = 1'b0;
  logic       mon_ready = 1'b0;

  int send_idle_pct = 36;
  int recv_idle_pct = 55;
  int cycle_count = 0;
  int bad_results = 0;
  int payload_count = 0;

  payload_req_t payload_q[$];
  h264rtp_res_t nal_results_q[$];
  logic [7:0]   pkt_bytes[$];

  int phase_avc[PHASE_COUNT] = '{0, 0, 1, 0, 1, 0};
  int phase_limit[PHASE_COUNT] = '{262144, 60, 25, 1, 262144, 40};

  // Shadow of the configuration registers.
  logic        shadow_avc = 1'b0;
  logic [18:0] shadow_limit = 19'd262144;

  // Shadow of the parser and frame fill state.
  parse_phase_e pp_phase;
  logic [4:0]   pp_type;
  logic [2:0]   pp_skip;
  logic [15:0]  pp_unit_left;
  logic [7:0]   pp_hdr_bits;
  logic [18:0]  fill_committed;
  logic [18:0]  fill_pending;
  logic         frag_s;
  logic         frag_e;
  logic         unit_dropped;
  logic         unit_active;
  h264rtp_res_t step_res;

  h264rtp_in_if in_ch();
  h264rtp_out_if out_ch();

  assign in_ch.valid = drv_valid;
  assign in_ch.data_byte = drv_byte;
  assign in_ch.packet_start = drv_start;
  assign in_ch.packet_end = drv_end;
  assign in_ch.frame_clear = drv_clear;
  assign out_ch.ready = mon_ready;

  h264_rtp_depacketizer #(
    .MAX_FRAME_BYTES(FRAME_BYTES_MAX)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_if    (in_ch),
    .out_if   (out_ch)
  );

  always begin
    #5ns clk = 1'b1;
    #5ns clk = 1'b0;
  end

  // Effective limit is the smaller of the register and the build-time size.
  function automatic logic [19:0] frame_cap();
    if (shadow_limit > 19'(FRAME_BYTES_MAX)) begin
      return 20'(FRAME_BYTES_MAX);
    end
    return 20'(shadow_limit);
  endfunction

  // Offer one byte of the open unit to the frame store.
  function automatic void store_unit_byte(input logic [7:0] b);
    step_res.unit_start = !unit_active;
    unit_active = 1'b1;
    if (!unit_dropped) begin
      if (20'(fill_pending) + 20'd1 > frame_cap()) begin
        unit_dropped = 1'b1;
      end else begin
        step_res.out_valid = 1'b1;
        step_res.out_byte = b;
        step_res.out_offset = fill_pending[17:0];
        fill_pending = fill_pending + 19'd1;
      end
    end
  endfunction

  // Close the open unit: commit it or report it dropped.
  function automatic void close_unit();
    step_res.unit_end = 1'b1;
    if (unit_dropped) begin
      step_res.overflow = 1'b1;
    end else begin
      step_res.unit_ok = 1'b1;
      fill_committed = fill_pending;
    end
    fill_pending = fill_committed;
    unit_dropped = 1'b0;
    unit_active = 1'b0;
  endfunction

  // After a size field: a zero size has no unit and goes on to the next size.
  function automatic void enter_unit();
    pp_phase = (pp_unit_left == 16'd0) ? ST_SIZE_HI : ST_UNIT;
  endfunction

  // Work out the result that one payload byte causes.
  function automatic h264rtp_res_t depack_step(input payload_req_t r);
    step_res = '0;
    if (r.clear) begin
      fill_committed = '0;
      fill_pending = '0;
      unit_dropped = 1'b0;
    end
    if (r.pkt_start || pp_phase == ST_HEADER) begin
      // Payload header: any open unit is given up silently.
      fill_pending = fill_committed;
      unit_dropped = 1'b0;
      unit_active = 1'b0;
      pp_type = shadow_avc ? 5'd0 : r.data[4:0];
      frag_s = 1'b1;
      frag_e = 1'b1;
      if (pp_type == NAL_STAP_A) begin
        pp_phase = ST_SIZE_HI;
      end else if (pp_type >= NAL_STAP_B && pp_type <= NAL_MTAP24) begin
        pp_skip = 3'd2;
        pp_phase = ST_SKIP_HDR;
      end else if (pp_type == NAL_FU_A || pp_type == NAL_FU_B) begin
        pp_hdr_bits = r.data & 8'hE0;
        pp_phase = ST_FU_HDR;
      end else begin
        store_unit_byte(r.data);
        pp_phase = ST_PAYLOAD;
      end
    end else begin
      case (pp_phase)
        ST_SKIP_HDR: begin
          if (pp_skip != 3'd0) pp_skip = pp_skip - 3'd1;
          if (pp_skip == 3'd0) pp_phase = (pp_type == NAL_FU_B) ? ST_PAYLOAD : ST_SIZE_HI;
        end
        ST_SIZE_HI: begin
          pp_unit_left = {r.data, 8'h00};
          pp_phase = ST_SIZE_LO;
        end
        ST_SIZE_LO: begin
          pp_unit_left = {pp_unit_left[15:8], r.data};
          if (pp_type == NAL_MTAP16) begin
            pp_skip = 3'd3;
            pp_phase = ST_SKIP_UNIT;
          end else if (pp_type == NAL_MTAP24) begin
            pp_skip = 3'd4;
            pp_phase = ST_SKIP_UNIT;
          end else begin
            enter_unit();
          end
        end
        ST_SKIP_UNIT: begin
          if (pp_skip != 3'd0) pp_skip = pp_skip - 3'd1;
          if (pp_skip == 3'd0) enter_unit();
        end
        ST_UNIT: begin
          store_unit_byte(r.data);
          if (pp_unit_left != 16'd0) pp_unit_left = pp_unit_left - 16'd1;
          if (pp_unit_left == 16'd0) begin
            close_unit();
            pp_phase = ST_SIZE_HI;
          end
        end
        ST_FU_HDR: begin
          // A first fragment opens with the rebuilt NAL header.
          frag_s = r.data[7];
          frag_e = r.data[6];
          if (frag_s) store_unit_byte({pp_hdr_bits[7:5], r.data[4:0]});
          if (pp_type == NAL_FU_B) begin
            pp_skip = 3'd2;
            pp_phase = ST_SKIP_HDR;
          end else begin
            pp_phase = ST_PAYLOAD;
          end
        end
        default: begin
          store_unit_byte(r.data);
        end
      endcase
    end
    if (r.pkt_end) begin
      // Ending inside a DON, FU header, size or MTAP extra field is short.
      if (pp_phase == ST_SKIP_HDR || pp_phase == ST_SIZE_LO ||
          pp_phase == ST_SKIP_UNIT || pp_phase == ST_FU_HDR) begin
        step_res.short_packet = 1'b1;
      end
      if (unit_active) close_unit();
      pp_phase = ST_HEADER;
    end
    step_res.frag_first = frag_s;
    step_res.frag_last = frag_e;
    step_res.nal_type = pp_type;
    return step_res;
  endfunction

  function automatic string res_text(input h264rtp_res_t r);
    return $sformatf({"valid=%0b byte=%02h offset=%0d start=%0b end=%0b ok=%0b ",
                      "ovf=%0b short=%0b ffirst=%0b flast=%0b type=%0d"},
                     r.out_valid, r.out_byte, r.out_offset, r.unit_start, r.unit_end,
                     r.unit_ok, r.overflow, r.short_packet, r.frag_first, r.frag_last,
                     r.nal_type);
  endfunction

  function automatic void push_req(input logic [7:0] d, input logic ps, input logic pe,
                                   input logic fc);
    payload_req_t r;
    r.data = d;
    r.pkt_start = ps;
    r.pkt_end = pe;
    r.clear = fc;
    payload_q.push_back(r);
    payload_count++;
  endfunction

  function automatic void add_body(input int unsigned n);
    repeat (n) pkt_bytes.push_back(8'($urandom));
  endfunction

  // Build one packet, mostly well formed, and queue its bytes.
  task automatic add_random_packet();
    int unsigned pick;
    int unsigned nunits;
    int unsigned body;
    int unsigned sz;
    int unsigned len;
    int unsigned extra;
    logic [7:0]  hdr;
    logic [4:0]  kind;
    pkt_bytes.delete();
    pick = $urandom_range(0, 99);
    if (pick >= 92) begin
      // Loose bytes with arbitrary marks.
      repeat ($urandom_range(1, 6)) begin
        push_req(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 5) == 0,
                 $urandom_range(0, 49) == 0);
      end
      return;
    end
    if (pick < 14) begin
      kind = 5'($urandom_range(0, 25));
      if (kind >= NAL_STAP_A) kind = kind + 5'd6;
    end else if (pick < 32) begin
      kind = NAL_STAP_A;
    end else if (pick < 42) begin
      kind = NAL_STAP_B;
    end else if (pick < 52) begin
      kind = NAL_MTAP16;
    end else if (pick < 62) begin
      kind = NAL_MTAP24;
    end else if (pick < 78) begin
      kind = NAL_FU_A;
    end else begin
      kind = NAL_FU_B;
    end
    hdr = 8'($urandom);
    hdr[4:0] = kind;
    pkt_bytes.push_back(hdr);
    if (kind == NAL_FU_A || kind == NAL_FU_B) begin
      // FU header with random start and end bits, then DON for FU-B.
      pkt_bytes.push_back(8'($urandom));
      if (kind == NAL_FU_B) add_body(2);
      add_body($urandom_range(0, 16));
    end else if (kind >= NAL_STAP_A && kind <= NAL_MTAP24) begin
      if (kind != NAL_STAP_A) add_body(2);
      extra = (kind == NAL_MTAP16) ? 3 : (kind == NAL_MTAP24) ? 4 : 0;
      nunits = $urandom_range(1, 4);
      for (int u = 0; u < nunits; u++) begin
        body = ($urandom_range(0, 99) < 10) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        sz = body;
        // Sometimes the last unit claims more than the packet holds.
        if (u == nunits - 1 && $urandom_range(0, 99) < 10) sz = $urandom_range(body + 1, 65535);
        pkt_bytes.push_back(sz[15:8]);
        pkt_bytes.push_back(sz[7:0]);
        add_body(extra);
        add_body(body);
      end
    end else begin
      add_body($urandom_range(0, 16));
    end
    len = pkt_bytes.size();
    if ($urandom_range(0, 99) < 8) len = $urandom_range(1, len);
    for (int i = 0; i < len; i++) begin
      push_req(pkt_bytes[i], i == 0 && $urandom_range(0, 99) >= 4,
               i == len - 1 && $urandom_range(0, 99) >= 4, $urandom_range(0, 99) < 2);
    end
  endtask

  task automatic write_reg(input logic idx, input logic [18:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_AVC_MODE) begin
      shadow_avc = val[0];
    end else begin
      shadow_limit = val;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold off until every queued byte is taken and every result is back.
  task automatic wait_drained();
    while (payload_q.size() != 0 || drv_valid || nal_results_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Byte driver: records the result of each accepted request.
  always @(posedge clk) begin : driver
    payload_req_t nxt;
    payload_req_t cur;
    if (!rst_n) begin
      drv_valid <= 1'b0;
      pp_phase = ST_HEADER;
      pp_type = '0;
      pp_skip = '0;
      pp_unit_left = '0;
      pp_hdr_bits = '0;
      fill_committed = '0;
      fill_pending = '0;
      frag_s = 1'b1;
      frag_e = 1'b1;
      unit_dropped = 1'b0;
      unit_active = 1'b0;
    end else begin
      if (drv_valid && in_ch.ready) begin
        cur.data = drv_byte;
        cur.pkt_start = drv_start;
        cur.pkt_end = drv_end;
        cur.clear = drv_clear;
        nal_results_q.push_back(depack_step(cur));
      end
      if (!drv_valid || in_ch.ready) begin
        if (payload_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = payload_q.pop_front();
          drv_valid <= 1'b1;
          drv_byte <= nxt.data;
          drv_start <= nxt.pkt_start;
          drv_end <= nxt.pkt_end;
          drv_clear <= nxt.clear;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: every accepted result is checked against the oldest prediction.
  always @(posedge clk) begin : monitor
    h264rtp_res_t got;
    h264rtp_res_t want;
    if (!rst_n) begin
      mon_ready <= 1'b0;
    end else begin
      if (out_ch.valid && mon_ready) begin
        got.out_valid = out_ch.out_valid;
        got.out_byte = out_ch.out_byte;
        got.out_offset = out_ch.out_offset;
        got.unit_start = out_ch.unit_start;
        got.unit_end = out_ch.unit_end;
        got.unit_ok = out_ch.unit_ok;
        got.overflow = out_ch.overflow;
        got.short_packet = out_ch.short_packet;
        got.frag_first = out_ch.frag_first;
        got.frag_last = out_ch.frag_last;
        got.nal_type = out_ch.nal_type;
        if (nal_results_q.size() == 0) begin
          if (bad_results < 10) $display("Unexpected result: %s", res_text(got));
          bad_results++;
        end else begin
          want = nal_results_q.pop_front();
          if (got !== want) begin
            if (bad_results < 10) begin
              $display("Mismatch at cycle %0d\n  expected %s\n  actual   %s",
                       cycle_count, res_text(want), res_text(got));
            end
            bad_results++;
          end
        end
      end
      mon_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int phase_base;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: single unit, STAP-A with zero, normal and cut units.
    push_req(8'h65, 1'b1, 1'b0, 1'b0);
    push_req(8'hFF, 1'b0, 1'b0, 1'b0);
    push_req(8'h00, 1'b0, 1'b1, 1'b0);
    push_req({3'b000, NAL_STAP_A}, 1'b1, 1'b0, 1'b0);
    push_req(8'h00, 1'b0, 1'b0, 1'b0);
    push_req(8'h00, 1'b0, 1'b0, 1'b0);
    push_req(8'h00, 1'b0, 1'b0, 1'b0);
    push_req(8'h02, 1'b0, 1'b0, 1'b0);
    push_req(8'hAA, 1'b0, 1'b0, 1'b0);
    push_req(8'h55, 1'b0, 1'b0, 1'b0);
    push_req(8'hFF, 1'b0, 1'b0, 1'b0);
    push_req(8'hFF, 1'b0, 1'b0, 1'b0);
    push_req(8'h11, 1'b0, 1'b1, 1'b0);
    // First FU-A fragment, then a last FU-B fragment with a frame clear.
    push_req({3'b011, NAL_FU_A}, 1'b1, 1'b0, 1'b0);
    push_req(8'h85, 1'b0, 1'b0, 1'b0);
    push_req(8'h12, 1'b0, 1'b1, 1'b0);
    push_req({3'b100, NAL_FU_B}, 1'b1, 1'b0, 1'b0);
    push_req(8'h41, 1'b0, 1'b0, 1'b0);
    push_req(8'h00, 1'b0, 1'b0, 1'b0);
    push_req(8'h07, 1'b0, 1'b0, 1'b0);
    push_req(8'h33, 1'b0, 1'b1, 1'b1);
    // Short packets, the second one with a header that lacks its start mark.
    push_req({3'b111, NAL_MTAP24}, 1'b1, 1'b0, 1'b0);
    push_req(8'h00, 1'b0, 1'b1, 1'b0);
    push_req({3'b000, NAL_STAP_B}, 1'b0, 1'b1, 1'b0);
    wait_drained();

    // Random phases, each under its own register settings.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (p == 2) begin
        send_idle_pct = 55;
        recv_idle_pct = 36;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(CFG_AVC_MODE, 19'(phase_avc[p]));
      write_reg(CFG_MAX_FRAME_LIMIT, 19'(phase_limit[p]));
      phase_base = payload_count;
      while (payload_count - phase_base < PHASE_BYTES) add_random_packet();
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (bad_results == 0 && nal_results_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/h264rtp_pkg.sv
src/h264rtp_ifs.sv
src/h264rtp_front.sv
src/h264rtp_queue.sv
src/h264rtp_back.sv
src/h264_rtp_depacketizer.sv
src/h264rtp_checker.sv
dv/testbench.sv
